FILE: src/plti_pkg.sv
// Shared types and constants for the piecewise-linear table interpolator.
// No dependencies; compiled before every other file of the block.
package plti_pkg;

  // default table depth, overridable from the top level
  localparam int unsigned MAX_POINTS_DEF = 16;

  // field widths
  localparam int unsigned XW   = 16;  // x and y, unsigned Q8.8
  localparam int unsigned IDXW = 4;   // point_index field
  localparam int unsigned PCW  = 5;   // point_count register

  // divider widths: |dq * dy| < 2**32, |dx| < 2**16
  localparam int unsigned NUMW = 32;
  localparam int unsigned DENW = 16;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam logic        REG_POINT_COUNT = 1'b0;
  localparam logic [PCW-1:0] POINT_COUNT_RST = 5'd15;
  localparam logic [PCW-1:0] POINT_COUNT_MIN = 5'd2;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SAT       = 2'd1,
    ST_ZERO_SPAN = 2'd2,
    ST_LOAD      = 2'd3
  } plti_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RD0,
    S_RD1,
    S_DIFF,
    S_MUL,
    S_SIGN,
    S_DIV,
    S_FIN,
    S_OUT
  } plti_state_e;

  // one breakpoint as stored in the table memory
  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
  } plti_point_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } plti_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } plti_div_sts_t;

endpackage

FILE: src/plti_in_if.sv
// Input channel of the interpolator: load and query items.
// Depends on plti_pkg for field widths.
interface plti_in_if import plti_pkg::*;;
  logic            valid;
  logic            ready;
  logic            kind;
  logic [IDXW-1:0] point_index;
  logic [XW-1:0]   point_x;
  logic [XW-1:0]   point_y;
  logic [XW-1:0]   query_x;

  modport source (output valid, kind, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink   (input valid, kind, point_index, point_x, point_y, query_x,
                  output ready);
endinterface

FILE: src/plti_out_if.sv
// Output channel of the interpolator: one result item per input item.
// Depends on plti_pkg for field widths.
interface plti_out_if import plti_pkg::*;;
  logic          valid;
  logic          ready;
  logic [XW-1:0] interp_value;
  logic [1:0]    status;

  modport source (output valid, interp_value, status, input ready);
  modport sink   (input valid, interp_value, status, output ready);
endinterface

FILE: src/plti_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plti_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/plti_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on plti_pkg for the handshake structs.
module plti_div import plti_pkg::*; #(
  parameter int unsigned NW = NUMW,
  parameter int unsigned DW = DENW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  plti_div_req_t req_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output plti_div_sts_t sts_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   den_q, den_d;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            ge;

  // one restoring step
  assign rem_sh  = {rem_q, quo_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(NW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NW-2:0], ge};
      rem_d = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;
  assign rem_o      = rem_q;

endmodule

FILE: src/piecewise_linear_table_interp.sv
// Piecewise-linear interpolation over a breakpoint table of MAX_POINTS
// entries (x ascending, y, both unsigned Q8.8). A load item writes one entry
// and is acknowledged with a result of status ST_LOAD. A query item works
// over n active points (point_count clamped to 2..MAX_POINTS): a serial
// segment search reads one entry per cycle through the table's single read
// port, then one multiply and a 32-step restoring divide set the rest. A
// zero-span segment returns without the multiply and the divide.
// The input is not ready while an item is being worked; a finished result
// waits in the output register so the next item can be taken meanwhile.
// Depends on plti_pkg, plti_in_if, plti_out_if, plti_ram and plti_div.
module piecewise_linear_table_interp import plti_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // item channels
  plti_in_if.sink           in_item,
  plti_out_if.source        out_item
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // ---------------------------------------------------------------------
  // configuration register
  logic [PCW-1:0] pc_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_POINT_COUNT);
  assign prdata = (paddr[APB_AW-1:2] == REG_POINT_COUNT) ? 32'(pc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= POINT_COUNT_RST;
    end else if (cfg_wr) begin
      pc_q <= pwdata[PCW-1:0];
    end
  end

  // active point count, clamped to 2..MAX_POINTS
  logic [CW-1:0] n_pts;
  logic [CW-1:0] n_m2;

  always_comb begin
    if (pc_q < POINT_COUNT_MIN) begin
      n_pts = CW'(2);
    end else if (int'(pc_q) > MAX_POINTS) begin
      n_pts = CW'(MAX_POINTS);
    end else begin
      n_pts = CW'(pc_q);
    end
  end

  assign n_m2 = n_pts - CW'(2);

  // ---------------------------------------------------------------------
  // breakpoint table
  logic        in_acc;
  logic [6:0]  idx_ext;
  logic        tbl_we;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  plti_point_t wr_pt;
  plti_point_t rd_pt;

  assign in_acc  = in_item.valid && in_item.ready;
  assign idx_ext = 7'(in_item.point_index);
  assign tbl_we  = in_acc && (in_item.kind == KIND_LOAD) && (int'(idx_ext) < MAX_POINTS);
  assign wr_pt.x = in_item.point_x;
  assign wr_pt.y = in_item.point_y;

  plti_ram #(
    .WIDTH ($bits(plti_point_t)),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .wr_addr_i (idx_ext[AW-1:0]),
    .wr_data_i (wr_pt),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_pt)
  );

  // ---------------------------------------------------------------------
  // divider
  plti_div_req_t     div_req;
  plti_div_sts_t     div_sts;
  logic [NUMW-1:0]   div_num;
  logic [DENW-1:0]   div_den;
  logic [NUMW-1:0]   div_quo;
  logic [DENW-1:0]   div_rem;

  plti_div #(
    .NW (NUMW),
    .DW (DENW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .sts_o  (div_sts),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // ---------------------------------------------------------------------
  // sequencer registers
  plti_state_e state_q, state_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          cmp_v_q, cmp_v_d;
  logic [AW-1:0] cmp_idx_q, cmp_idx_d;
  logic [AW-1:0] k_q, k_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic [XW-1:0]        qx_q, qx_d;
  logic [XW-1:0]        x0_q, x0_d;
  logic [XW-1:0]        y0_q, y0_d;
  logic signed [XW:0]   dq_q, dq_d;
  logic signed [XW:0]   dy_q, dy_d;
  logic signed [XW:0]   dx_q, dx_d;
  logic signed [2*XW+1:0] prod_q, prod_d;
  logic                 neg_q, neg_d;
  logic [NUMW:0]        qr_q, qr_d;
  logic [XW-1:0]        res_val_q, res_val_d;
  plti_status_e         res_st_q, res_st_d;
  logic [XW-1:0]        out_val_q, out_val_d;
  plti_status_e         out_st_q, out_st_d;

  // helpers
  logic [AW-1:0]          k_clamp;
  logic                   out_free;
  logic signed [2*XW+1:0] prod_abs;
  logic signed [XW:0]     dx_abs;
  logic                   rnd_up;
  logic signed [NUMW+2:0] q_signed;
  logic signed [NUMW+2:0] v_sum;

  assign k_clamp  = (CW'(k_q) > n_m2) ? n_m2[AW-1:0] : k_q;
  assign out_free = !out_valid_q || out_item.ready;
  assign prod_abs = prod_q[2*XW+1] ? -prod_q : prod_q;
  assign dx_abs   = dx_q[XW] ? -dx_q : dx_q;
  assign div_num  = prod_abs[NUMW-1:0];
  assign div_den  = dx_abs[DENW-1:0];
  assign rnd_up   = ({1'b0, div_rem, 1'b0} >= {2'b0, div_den});
  assign q_signed = neg_q ? -$signed({2'b0, qr_q}) : $signed({2'b0, qr_q});
  assign v_sum    = $signed({{(NUMW+3-XW){1'b0}}, y0_q}) + q_signed;

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    cmp_v_d     = cmp_v_q;
    cmp_idx_d   = cmp_idx_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    qx_d        = qx_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    dq_d        = dq_q;
    dy_d        = dy_q;
    dx_d        = dx_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    qr_d        = qr_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    div_req     = '0;

    // output register drains independently
    if (out_item.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item.kind == KIND_LOAD) begin
            res_val_d = '0;
            res_st_d  = ST_LOAD;
            state_d   = S_OUT;
          end else begin
            qx_d    = in_item.query_x;
            scan_d  = '0;
            cmp_v_d = 1'b0;
            k_d     = '0;
            state_d = S_SCAN;
          end
        end
      end

      // one table read per cycle; each entry is compared once its registered read data returns
      S_SCAN: begin
        if (cmp_v_q && (qx_q >= rd_pt.x)) begin
          k_d = cmp_idx_q;
        end
        if (scan_q != n_pts) begin
          rd_en     = 1'b1;
          rd_addr   = scan_q[AW-1:0];
          cmp_v_d   = 1'b1;
          cmp_idx_d = scan_q[AW-1:0];
          scan_d    = scan_q + CW'(1);
        end else begin
          cmp_v_d = 1'b0;
          state_d = S_RD0;
        end
      end

      // lower breakpoint, segment limited to the last one
      S_RD0: begin
        rd_en   = 1'b1;
        rd_addr = k_clamp;
        k_d     = k_clamp;
        state_d = S_RD1;
      end

      S_RD1: begin
        rd_en   = 1'b1;
        rd_addr = k_q + AW'(1);
        x0_d    = rd_pt.x;
        y0_d    = rd_pt.y;
        state_d = S_DIFF;
      end

      // spans of the segment; zero span returns the lower y
      S_DIFF: begin
        if (rd_pt.x == x0_q) begin
          res_val_d = y0_q;
          res_st_d  = ST_ZERO_SPAN;
          state_d   = S_OUT;
        end else begin
          dq_d    = $signed({1'b0, qx_q}) - $signed({1'b0, x0_q});
          dy_d    = $signed({1'b0, rd_pt.y}) - $signed({1'b0, y0_q});
          dx_d    = $signed({1'b0, rd_pt.x}) - $signed({1'b0, x0_q});
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        prod_d  = dq_q * dy_q;
        state_d = S_SIGN;
      end

      S_SIGN: begin
        div_req.start = 1'b1;
        neg_d         = prod_q[2*XW+1] ^ dx_q[XW];
        state_d       = S_DIV;
      end

      // round half away from zero on the magnitude
      S_DIV: begin
        if (div_sts.done) begin
          qr_d    = {1'b0, div_quo} + (NUMW+1)'(rnd_up);
          state_d = S_FIN;
        end
      end

      // add base and saturate to 16 bits
      S_FIN: begin
        if (v_sum < 0) begin
          res_val_d = '0;
          res_st_d  = ST_SAT;
        end else if (v_sum > $signed((NUMW+3)'(2**XW - 1))) begin
          res_val_d = '1;
          res_st_d  = ST_SAT;
        end else begin
          res_val_d = v_sum[XW-1:0];
          res_st_d  = ST_OK;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      cmp_v_q     <= 1'b0;
      cmp_idx_q   <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      cmp_v_q     <= cmp_v_d;
      cmp_idx_q   <= cmp_idx_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    qx_q      <= qx_d;
    x0_q      <= x0_d;
    y0_q      <= y0_d;
    dq_q      <= dq_d;
    dy_q      <= dy_d;
    dx_q      <= dx_d;
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    qr_q      <= qr_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  // ports
  assign in_item.ready         = (state_q == S_IDLE);
  assign out_item.valid        = out_valid_q;
  assign out_item.interp_value = out_val_q;
  assign out_item.status       = out_st_q;

endmodule

FILE: src/plti_checker.sv
// Port-level checks for the interpolator, bound to the top level.
// Depends on plti_pkg, plti_in_if, plti_out_if and the top level.
module plti_checker import plti_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  plti_in_if.sink           in_item,
  plti_out_if.source        out_item
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_item.valid && !out_item.ready |=>
      out_item.valid && $stable(out_item.interp_value) && $stable(out_item.status))
    else $error("result item changed while stalled");

  // the block is busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_item.valid && in_item.ready |=> !in_item.ready)
    else $error("input ready right after an accepted item");

  // a saturated result sits at one of the rails
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_item.valid && out_item.status == ST_SAT |->
      out_item.interp_value == '0 || out_item.interp_value == '1)
    else $error("saturated result not at a rail");

  // point_count reads back what was written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[APB_AW-1:2] == REG_POINT_COUNT |=>
      paddr[APB_AW-1:2] != REG_POINT_COUNT || prdata[PCW-1:0] == $past(pwdata[PCW-1:0]))
    else $error("point_count readback mismatch");

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .in_item  (in_item),
  .out_item (out_item)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_table_interp: breakpoint loads and
// queries under random handshake gaps, every result checked against a local predictor.
// Depends on plti_pkg, plti_in_if, plti_out_if and the block itself.
module tb_top import plti_pkg::*;;

  localparam int unsigned TAB_DEPTH    = MAX_POINTS_DEF;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PRINT_CAP    = 200;
  localparam longint     VAL_MAX      = 2 ** XW - 1;

  typedef struct packed {
    logic            kind;
    logic [IDXW-1:0] point_index;
    logic [XW-1:0]   point_x;
    logic [XW-1:0]   point_y;
    logic [XW-1:0]   query_x;
  } plti_item_t;

  typedef struct packed {
    logic [XW-1:0] interp_value;
    plti_status_e  status;
  } plti_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  plti_in_if  in_if ();
  plti_out_if out_if ();

  piecewise_linear_table_interp dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_item  (in_if),
    .out_item (out_if)
  );

  // table and point count as the block should hold them
  logic [XW-1:0]  model_x [TAB_DEPTH];
  logic [XW-1:0]  model_y [TAB_DEPTH];
  logic [PCW-1:0] model_count;

  // items waiting to be offered, results waiting to arrive
  plti_item_t   queued_items [$];
  plti_result_t awaited_results [$];

  // stimulus knobs, set at start and otherwise written at the falling edge only
  int unsigned send_gap_max;
  int unsigned recv_stall_max;
  int unsigned hold_kicks;

  // x values as the generator has loaded them, used to aim queries
  logic [XW-1:0] gen_x [TAB_DEPTH];

  int unsigned mismatch_count = 0;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // interpolated y for one item, updating the table on loads
  function automatic plti_result_t predict_interp(input plti_item_t it);
    plti_result_t res;
    int unsigned  n;
    int unsigned  seg;
    longint       x0, x1, y0, y1, num, den, mag_n, mag_d, quo, val;
    res.interp_value = '0;
    res.status       = ST_LOAD;
    if (it.kind == KIND_LOAD) begin
      model_x[it.point_index] = it.point_x;
      model_y[it.point_index] = it.point_y;
      return res;
    end
    // active points, clamped to the table
    n = model_count;
    if (n < POINT_COUNT_MIN) n = POINT_COUNT_MIN;
    if (n > TAB_DEPTH) n = TAB_DEPTH;
    // last breakpoint not above the query, held inside the table
    seg = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (it.query_x >= model_x[i]) seg = i;
    end
    if (seg > n - 2) seg = n - 2;
    x0 = longint'(model_x[seg]);
    x1 = longint'(model_x[seg + 1]);
    y0 = longint'(model_y[seg]);
    y1 = longint'(model_y[seg + 1]);
    if (x1 == x0) begin
      res.interp_value = model_y[seg];
      res.status       = ST_ZERO_SPAN;
      return res;
    end
    // exact product, quotient rounded to nearest with ties away from zero
    num   = (longint'(it.query_x) - x0) * (y1 - y0);
    den   = x1 - x0;
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    quo   = mag_n / mag_d;
    if (2 * (mag_n % mag_d) >= mag_d) quo++;
    if ((num < 0) != (den < 0)) quo = -quo;
    val = y0 + quo;
    if (val < 0) begin
      res.interp_value = '0;
      res.status       = ST_SAT;
    end else if (val > VAL_MAX) begin
      res.interp_value = '1;
      res.status       = ST_SAT;
    end else begin
      res.interp_value = val[XW-1:0];
      res.status       = ST_OK;
    end
    return res;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // item driver: offers queued items with random gaps, predicts on acceptance
  plti_item_t  offered_item;
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.kind        <= KIND_LOAD;
      in_if.point_index <= '0;
      in_if.point_x     <= '0;
      in_if.point_y     <= '0;
      in_if.query_x     <= '0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        awaited_results.insert(awaited_results.size(), predict_interp(offered_item));
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (queued_items.size() != 0) begin
          offered_item = queued_items.pop_front();
          in_if.valid       <= 1'b1;
          in_if.kind        <= offered_item.kind;
          in_if.point_index <= offered_item.point_index;
          in_if.point_x     <= offered_item.point_x;
          in_if.point_y     <= offered_item.point_y;
          in_if.query_x     <= offered_item.query_x;
          send_gap = $urandom_range(0, send_gap_max);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random stalls, long hold on request, field checks
  int unsigned  recv_stall;
  int unsigned  hold_left;
  int unsigned  hold_seen;
  plti_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall = 0;
      hold_left  = 0;
      hold_seen  = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected item value %h status %0d",
                                  out_if.interp_value, out_if.status));
        end else begin
          want = awaited_results.pop_front();
          if (out_if.interp_value !== want.interp_value || out_if.status !== want.status)
            flag_mismatch($sformatf("value %h want %h, status %0d want %0d",
                                    out_if.interp_value, want.interp_value,
                                    out_if.status, want.status));
        end
        recv_stall = $urandom_range(0, recv_stall_max);
      end
      if (hold_seen != hold_kicks) begin
        hold_seen = hold_kicks;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // wait until nothing is queued, offered or awaited
  task automatic wait_idle();
    do @(negedge clk_i);
    while (queued_items.size() != 0 || in_if.valid || awaited_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // setup and access cycle on the configuration port
  task automatic write_point_count(input logic [PCW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({REG_POINT_COUNT, 2'b00});
    pwdata  <= {(32 - PCW)'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_count = value;
    @(negedge clk_i);
  endtask

  task automatic add_load(input logic [IDXW-1:0] idx, input logic [XW-1:0] xv,
                          input logic [XW-1:0] yv);
    gen_x[idx] = xv;
    queued_items.insert(queued_items.size(),
                        plti_item_t'{kind: KIND_LOAD, point_index: idx, point_x: xv,
                                     point_y: yv, query_x: XW'($urandom)});
  endtask

  task automatic add_query(input logic [XW-1:0] qv);
    queued_items.insert(queued_items.size(),
                        plti_item_t'{kind: KIND_QUERY, point_index: IDXW'($urandom),
                                     point_x: XW'($urandom), point_y: XW'($urandom),
                                     query_x: qv});
  endtask

  // one setting of point_count: fresh table over the active points, then mixed items
  task automatic run_phase(input logic [PCW-1:0] count, input int unsigned n_items,
                           input bit long_hold);
    int unsigned n;
    int unsigned layout;
    int unsigned pick;
    int unsigned xacc;
    int unsigned lim;
    int          near;
    wait_idle();
    write_point_count(count);
    n = count;
    if (n < POINT_COUNT_MIN) n = POINT_COUNT_MIN;
    if (n > TAB_DEPTH) n = TAB_DEPTH;
    send_gap_max   = ($urandom_range(0, 2) == 0 || long_hold) ? 0 : 5;
    recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
    if (long_hold) hold_kicks++;

    // table fill: mostly ascending, some with repeated x, some unordered
    layout = $urandom_range(0, 9);
    xacc   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4000);
    for (int unsigned i = 0; i < n; i++) begin
      if (layout >= 8) begin
        add_load(IDXW'(i), XW'($urandom), XW'($urandom));
      end else begin
        add_load(IDXW'(i), XW'(xacc), XW'($urandom));
        lim = (65535 - xacc) / (n - i);
        if (lim == 0) lim = 1;
        if (!(layout >= 6 && $urandom_range(0, 3) == 0)) xacc += $urandom_range(1, lim);
        if (xacc > 65535) xacc = 65535;
      end
    end

    // queries aimed at the table, plus stray loads as noise
    for (int unsigned k = n; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        add_load(IDXW'($urandom), XW'($urandom), XW'($urandom));
      end else if (pick < 35) begin
        add_query(XW'($urandom));
      end else if (pick < 60) begin
        near = int'(gen_x[$urandom_range(0, n - 1)]) + int'($urandom_range(0, 6)) - 3;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        add_query(XW'(near));
      end else if (pick < 68) begin
        add_query(($urandom_range(0, 1) != 0) ? '1 : '0);
      end else begin
        add_query(XW'($urandom_range(gen_x[0], gen_x[n - 1])));
      end
    end
  endtask

  // reset, directed items, random phases, final verdict
  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_LOAD;
    in_if.point_index = '0;
    in_if.point_x     = '0;
    in_if.point_y     = '0;
    in_if.query_x     = '0;
    out_if.ready      = 1'b0;
    send_gap_max      = 5;
    recv_stall_max    = 5;
    hold_kicks        = 0;
    model_count       = POINT_COUNT_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // count below the minimum acts as two points
    write_point_count('0);
    add_load(4'd15, '1, '0);
    add_load(4'd0, 16'h0100, 16'h8000);
    add_load(4'd1, 16'h0200, 16'hFFFF);
    add_query('0);            // extrapolate below the first point
    add_query('1);            // beyond the last point, saturates high
    add_query(16'h0180);      // midpoint, positive tie
    add_query(16'h0100);      // exactly on a breakpoint
    add_query(16'h0200);      // on the last breakpoint
    add_load(4'd1, 16'h0200, '0);
    add_query('1);            // falling segment, saturates low
    add_load(4'd1, 16'h0100, 16'h1234);
    add_query('0);            // zero span
    add_query('1);
    add_load(4'd0, '1, '0);
    add_load(4'd1, '0, '1);
    add_query(16'h8000);      // unordered table, negative span
    add_query('0);            // lands exactly on the top of the range
    add_load(4'd0, 16'h0100, 16'h8000);
    add_load(4'd1, 16'h0102, 16'h7FFF);
    add_query(16'h0101);      // negative tie
    add_query(16'h0102);

    run_phase(5'd31, 45, 1'b0);
    run_phase(5'd16, 45, 1'b1);
    run_phase(5'd1, 30, 1'b0);
    run_phase(5'd17, 40, 1'b0);
    run_phase(5'd2, 30, 1'b0);
    run_phase(5'd15, 40, 1'b0);
    repeat (6) run_phase(PCW'($urandom_range(0, 31)), 40, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
